[hdl/oqct_pkg.sv]
// Shared types, codes and reset values of the orientation-qualified cycle timer.
package oqct_pkg;

  localparam int WINDOW_DEPTH_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [1:0] KIND_TILT   = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_BUTTON = 2'd2;

  localparam logic [1:0] BTN_FIRST  = 2'd0;
  localparam logic [1:0] BTN_BOOST  = 2'd1;
  localparam logic [1:0] BTN_SECOND = 2'd2;

  localparam logic signed [1:0] ORIENT_NONE = 2'sb00;
  localparam logic signed [1:0] ORIENT_UP   = 2'sb01;
  localparam logic signed [1:0] ORIENT_DOWN = 2'sb11;

  localparam logic [CFG_IDX_W-1:0] CFG_TILT_THRESHOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PRESCALE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MODE_ON      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MODE_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MODE_CYCLES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MODE_ON     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MODE_PERIOD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MODE_CYCLES = 3'd7;

  localparam logic [6:0]  RST_TILT_THRESHOLD     = 7'd12;
  localparam logic [6:0]  RST_TICK_PRESCALE      = 7'd64;
  localparam logic [11:0] RST_FIRST_MODE_ON      = 12'd900;
  localparam logic [11:0] RST_FIRST_MODE_PERIOD  = 12'd2700;
  localparam logic [8:0]  RST_FIRST_MODE_CYCLES  = 9'd3;
  localparam logic [11:0] RST_SECOND_MODE_ON     = 12'd10;
  localparam logic [11:0] RST_SECOND_MODE_PERIOD = 12'd70;
  localparam logic [8:0]  RST_SECOND_MODE_CYCLES = 9'd412;

  typedef struct packed {
    logic [6:0]  tilt_threshold;
    logic [6:0]  tick_prescale;
    logic [11:0] first_mode_on;
    logic [11:0] first_mode_period;
    logic [8:0]  first_mode_cycles;
    logic [11:0] second_mode_on;
    logic [11:0] second_mode_period;
    logic [8:0]  second_mode_cycles;
  } cfg_t;

endpackage

[hdl/oqct_cfg.sv]
// Configuration register file.
module oqct_cfg
  import oqct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg_o
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tilt_threshold     <= RST_TILT_THRESHOLD;
      cfg_r.tick_prescale      <= RST_TICK_PRESCALE;
      cfg_r.first_mode_on      <= RST_FIRST_MODE_ON;
      cfg_r.first_mode_period  <= RST_FIRST_MODE_PERIOD;
      cfg_r.first_mode_cycles  <= RST_FIRST_MODE_CYCLES;
      cfg_r.second_mode_on     <= RST_SECOND_MODE_ON;
      cfg_r.second_mode_period <= RST_SECOND_MODE_PERIOD;
      cfg_r.second_mode_cycles <= RST_SECOND_MODE_CYCLES;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TILT_THRESHOLD:     cfg_r.tilt_threshold     <= cfg_data[6:0];
        CFG_TICK_PRESCALE:      cfg_r.tick_prescale      <= cfg_data[6:0];
        CFG_FIRST_MODE_ON:      cfg_r.first_mode_on      <= cfg_data;
        CFG_FIRST_MODE_PERIOD:  cfg_r.first_mode_period  <= cfg_data;
        CFG_FIRST_MODE_CYCLES:  cfg_r.first_mode_cycles  <= cfg_data[8:0];
        CFG_SECOND_MODE_ON:     cfg_r.second_mode_on     <= cfg_data;
        CFG_SECOND_MODE_PERIOD: cfg_r.second_mode_period <= cfg_data;
        CFG_SECOND_MODE_CYCLES: cfg_r.second_mode_cycles <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/oqct_tilt.sv]
// Tilt sample window and orientation decision.
module oqct_tilt
  import oqct_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic signed [7:0]   sample,
  input  logic [6:0]          threshold,
  output logic signed [1:0]   orient_o
);

  logic signed [7:0] win_r   [WINDOW_DEPTH];
  logic signed [7:0] win_nxt [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] up_vec;
  logic [WINDOW_DEPTH-1:0] down_vec;
  logic signed [8:0] thr_pos;
  logic signed [8:0] thr_neg;

  assign thr_pos = $signed({2'b00, threshold});
  assign thr_neg = -thr_pos;

  always_comb begin
    win_nxt[0] = sample;
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      up_vec[i]   = 9'(win_nxt[i]) > thr_pos;
      down_vec[i] = 9'(win_nxt[i]) < thr_neg;
    end
  end

  always_comb begin
    if (&up_vec) begin
      orient_o = ORIENT_UP;
    end else if (&down_vec) begin
      orient_o = ORIENT_DOWN;
    end else begin
      orient_o = ORIENT_NONE;
    end
  end

  // shift in the new sample; entry order does not matter for the decision
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      win_r <= win_nxt;
    end
  end

endmodule

[hdl/oqct_ctrl.sv]
// Mode, motor, prescaler and seconds control; its registers form the result beat.
module oqct_ctrl
  import oqct_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv_i,
  input  logic [1:0]         kind_i,
  input  logic [1:0]         button_i,
  input  logic signed [1:0]  tilt_orient_i,
  input  cfg_t               cfg_i,
  output logic signed [1:0]  orientation_o,
  output logic               motor_on_o,
  output logic               valve_on_o,
  output logic               boost_led_o,
  output logic               first_mode_led_o,
  output logic               second_mode_led_o,
  output logic               heartbeat_o
);

  logic signed [1:0] orient_r, orient_nxt;
  logic              mode_r, mode_nxt;
  logic              boost_r, boost_nxt;
  logic              motor_r, motor_nxt;
  logic              valve_r, valve_nxt;
  logic [2:0]        ind_r, ind_nxt;
  logic [11:0]       secs_r, secs_nxt;
  logic [8:0]        cyc_r, cyc_nxt;
  logic [6:0]        pre_r, pre_nxt;
  logic              hb_r, hb_nxt;
  logic              start;
  logic [6:0]        pre_inc;
  logic [11:0]       secs_inc;
  logic [8:0]        cyc_dec;
  logic [11:0]       on_time;
  logic [11:0]       period;

  assign pre_inc  = pre_r + 7'd1;
  assign secs_inc = secs_r + 12'd1;
  assign cyc_dec  = cyc_r - 9'd1;
  assign on_time  = mode_r ? cfg_i.second_mode_on : cfg_i.first_mode_on;
  assign period   = mode_r ? cfg_i.second_mode_period : cfg_i.first_mode_period;

  always_comb begin
    start      = 1'b0;
    orient_nxt = orient_r;
    mode_nxt   = mode_r;
    boost_nxt  = boost_r;
    motor_nxt  = motor_r;
    valve_nxt  = valve_r;
    ind_nxt    = ind_r;
    secs_nxt   = secs_r;
    cyc_nxt    = cyc_r;
    pre_nxt    = pre_r;
    hb_nxt     = hb_r;

    case (kind_i)
      KIND_TILT: begin
        if (tilt_orient_i != orient_r) begin
          orient_nxt = tilt_orient_i;
          start      = 1'b1;
        end
      end
      KIND_TICK: begin
        if (pre_inc != cfg_i.tick_prescale) begin
          pre_nxt = pre_inc;
        end else begin
          pre_nxt = '0;
          hb_nxt  = !hb_r;
          if (cyc_r != '0) begin
            secs_nxt = secs_inc;
            if (secs_inc == on_time) begin
              motor_nxt = 1'b0;
              valve_nxt = 1'b0;
            end
            if (secs_inc == period) begin
              cyc_nxt  = cyc_dec;
              secs_nxt = '0;
              if (cyc_dec == '0) begin
                motor_nxt = 1'b0;
                valve_nxt = 1'b0;
              end else begin
                motor_nxt = 1'b1;
                valve_nxt = orient_r[1];
              end
            end
          end
        end
      end
      KIND_BUTTON: begin
        if (orient_r != ORIENT_NONE) begin
          case (button_i)
            BTN_FIRST: begin
              mode_nxt = 1'b0;
              start    = 1'b1;
            end
            BTN_BOOST: begin
              boost_nxt  = !boost_r;
              ind_nxt[1] = !boost_r;
            end
            BTN_SECOND: begin
              mode_nxt = 1'b1;
              start    = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // restart the selected mode, or stop motor and valve when the orientation is none
    if (start) begin
      ind_nxt = '0;
      if (orient_nxt != ORIENT_NONE) begin
        ind_nxt[1] = boost_nxt;
        if (!mode_nxt) begin
          ind_nxt[0] = 1'b1;
          cyc_nxt    = cfg_i.first_mode_cycles;
        end else begin
          ind_nxt[2] = 1'b1;
          cyc_nxt    = cfg_i.second_mode_cycles;
        end
        secs_nxt  = '0;
        motor_nxt = 1'b1;
        valve_nxt = orient_nxt[1];
      end else begin
        motor_nxt = 1'b0;
        valve_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r <= ORIENT_NONE;
      mode_r   <= 1'b0;
      boost_r  <= 1'b0;
      motor_r  <= 1'b0;
      valve_r  <= 1'b0;
      ind_r    <= '0;
      secs_r   <= '0;
      cyc_r    <= '0;
      pre_r    <= '0;
      hb_r     <= 1'b0;
    end else if (adv_i) begin
      orient_r <= orient_nxt;
      mode_r   <= mode_nxt;
      boost_r  <= boost_nxt;
      motor_r  <= motor_nxt;
      valve_r  <= valve_nxt;
      ind_r    <= ind_nxt;
      secs_r   <= secs_nxt;
      cyc_r    <= cyc_nxt;
      pre_r    <= pre_nxt;
      hb_r     <= hb_nxt;
    end
  end

  assign orientation_o     = orient_r;
  assign motor_on_o        = motor_r;
  assign valve_on_o        = valve_r;
  assign boost_led_o       = ind_r[1];
  assign first_mode_led_o  = ind_r[0];
  assign second_mode_led_o = ind_r[2];
  assign heartbeat_o       = hb_r;

  a_valve_needs_motor: assert property (@(posedge clk) disable iff (!rst_n)
    valve_r |-> motor_r)
    else $error("valve driven with motor off");

  a_one_mode_led: assert property (@(posedge clk) disable iff (!rst_n)
    !(ind_r[0] && ind_r[2]))
    else $error("both mode indicators lit");

  a_orient_code: assert property (@(posedge clk) disable iff (!rst_n)
    orient_r != 2'sb10)
    else $error("invalid orientation code");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !adv_i |=> ($stable(hb_r) && $stable(pre_r) && $stable(orient_r)))
    else $error("state moved without a beat");

endmodule

[hdl/orientation_qualified_cycle_timer_unit.sv]
// An input beat is held in the input register and then updates the control state.
// Throughput: one item per cycle unless out_ready stalls; an empty input register
// accepts while a result waits. The result register is the control state, updated
// once per item. Reset (rst_n low, synchronous) clears the window, state and
// valid flags and loads the configuration reset values.
module orientation_qualified_cycle_timer_unit
  import oqct_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic signed [7:0]     in_tilt_sample,
  input  logic [1:0]            in_button,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [1:0]     out_orientation,
  output logic                  out_motor_on,
  output logic                  out_valve_on,
  output logic                  out_boost_led,
  output logic                  out_first_mode_led,
  output logic                  out_second_mode_led,
  output logic                  out_heartbeat,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              s1_valid_r;
  logic [1:0]        s1_kind_r;
  logic signed [7:0] s1_sample_r;
  logic [1:0]        s1_button_r;
  logic              out_valid_r;
  logic              adv;
  logic signed [1:0] tilt_orient;
  cfg_t              cfg;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r   <= in_kind;
      s1_sample_r <= in_tilt_sample;
      s1_button_r <= in_button;
    end
  end

  oqct_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  oqct_tilt #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_tilt (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (adv && (s1_kind_r == KIND_TILT)),
    .sample    (s1_sample_r),
    .threshold (cfg.tilt_threshold),
    .orient_o  (tilt_orient)
  );

  oqct_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv_i             (adv),
    .kind_i            (s1_kind_r),
    .button_i          (s1_button_r),
    .tilt_orient_i     (tilt_orient),
    .cfg_i             (cfg),
    .orientation_o     (out_orientation),
    .motor_on_o        (out_motor_on),
    .valve_on_o        (out_valve_on),
    .boost_led_o       (out_boost_led),
    .first_mode_led_o  (out_first_mode_led),
    .second_mode_led_o (out_second_mode_led),
    .heartbeat_o       (out_heartbeat)
  );

endmodule
